>>> design/bsp_pkg.sv
package bsp_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int unsigned DepthDefault     = 256;
  localparam int unsigned DataWidthDefault = 32;

  // Fixed field widths on the ports.
  localparam int unsigned LimitW     = 9;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountOutW  = 9;
  localparam int unsigned PeekDepthW = 9;

  localparam logic [LimitW-1:0] LimitReset = 9'd256;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADDEPTH  = 2'd3
  } status_e;

  typedef struct packed {
    action_e                 action;
    logic signed [ValueW-1:0] push_value;
    logic [PeekDepthW-1:0]   peek_depth;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    status_e                 status;
    logic                    is_empty;
    logic                    is_full;
    logic [CountOutW-1:0]    item_count;
  } result_t;

endpackage

>>> design/bsp_ram.sv
// Single-port synchronous RAM, registered read data.
module bsp_ram
  import bsp_pkg::*;
#(
  parameter int unsigned Depth     = DepthDefault,
  parameter int unsigned DataWidth = DataWidthDefault,
  parameter int unsigned AddrW     = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     addr_i,
  input  logic [DataWidth-1:0] wdata_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bounded_stack_with_peek_core.sv
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------
// request   | in        | start & !busy         | req_i    (req_t)
// result    | out       | done_o strobe, 1 cyc  | result_o (result_t)
// config    | in        | cfg_valid_i & ready   | cfg_data_i (stack limit)
//
// One request per cycle: busy stays low, so requests may arrive back to back.
// The result of a request shows on result_o in the cycle after it is taken;
// that delay comes from the registered read of the entry RAM.
// Reset clears the count and sets the limit to 256; RAM contents stay
// undefined and are only read after being written, so no clearing pass.
// The receiver cannot stall; each result is valid for its one strobe cycle.
module bounded_stack_with_peek_core
  import bsp_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output result_t           result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  // Common compare width for count, limit and peek depth.
  localparam int unsigned CmpW  = (CntW > LimitW) ? CntW : LimitW;

  logic                  accept;
  logic [CntW-1:0]       count_q, count_d;
  logic [LimitW-1:0]     limit_q;
  logic [CmpW-1:0]       lim_ext, eff_lim, cnt_ext, depth_ext, cnt_nxt_ext;

  // RAM access for the current request
  logic                  ram_en, ram_we;
  logic [AddrW-1:0]      ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]           push_wide;
  logic signed [63:0]    rd_wide;

  // Result register; read data comes straight from the RAM output register.
  logic                  done_q;
  logic                  rd_sel_q, rd_sel_d;
  status_e               status_q, status_d;
  logic                  empty_q, full_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Effective limit saturates at the RAM depth.
  assign lim_ext   = CmpW'(limit_q);
  assign eff_lim   = (lim_ext > CmpW'(DEPTH)) ? CmpW'(DEPTH) : lim_ext;
  assign cnt_ext   = CmpW'(count_q);
  assign depth_ext = CmpW'(req_i.peek_depth);

  // Pushed value: zero-extend then keep the low DATA_WIDTH bits.
  assign push_wide = 64'(unsigned'(req_i.push_value));
  assign ram_wdata = push_wide[DATA_WIDTH-1:0];

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    rd_sel_d = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = count_q[AddrW-1:0];
    if (accept) begin
      unique case (req_i.action)
        ACT_PUSH: begin
          if (cnt_ext >= eff_lim) begin
            status_d = ST_OVERFLOW;
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = count_q[AddrW-1:0];
            count_d  = count_q + CntW'(1);
          end
        end
        ACT_POP: begin
          if (count_q == '0) begin
            status_d = ST_UNDERFLOW;
          end else begin
            count_d  = count_q - CntW'(1);
            ram_en   = 1'b1;
            ram_addr = count_d[AddrW-1:0];
            rd_sel_d = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (depth_ext == '0 || depth_ext > cnt_ext) begin
            status_d = ST_BADDEPTH;
          end else begin
            ram_en   = 1'b1;
            ram_addr = AddrW'(cnt_ext - depth_ext);
            rd_sel_d = 1'b1;
          end
        end
        default: begin
          // no-op code
        end
      endcase
    end
  end

  assign cnt_nxt_ext = CmpW'(count_d);

  bsp_ram #(
    .Depth     (DEPTH),
    .DataWidth (DATA_WIDTH),
    .AddrW     (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LimitReset;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_sel_q <= rd_sel_d;
      status_q <= status_d;
      empty_q  <= (count_d == '0);
      full_q   <= (cnt_nxt_ext >= eff_lim);
    end
  end

  // Sign-extend the stored entry, then cut to the port width.
  assign rd_wide = 64'($signed(ram_rdata));

  assign done_o              = done_q;
  assign result_o.read_value = rd_sel_q ? rd_wide[ValueW-1:0] : '0;
  assign result_o.status     = status_q;
  assign result_o.is_empty   = empty_q;
  assign result_o.is_full    = full_q;
  assign result_o.item_count = CountOutW'(count_q);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request taken but no result strobe");

  a_no_spurious_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without request");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(DEPTH))
    else $error("entry count above depth");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_OVERFLOW) |-> result_o.is_full)
    else $error("overflow reported while not full");

  a_underflow_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_UNDERFLOW) |-> result_o.is_empty)
    else $error("underflow reported while not empty");

endmodule
